// ----- hdl/lse_pkg.sv -----
// ============================================================================
// lse_pkg
// Shared types and constants for the LSB stego extractor.
// ============================================================================
package lse_pkg;

    // Result status codes
    localparam logic [1:0] ST_PAYLOAD  = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    // Configuration register indexes
    localparam logic CFG_BITS_PER_CHANNEL = 1'b0;
    localparam logic CFG_KEY_BYTE         = 1'b1;

    // Three characters, entry 0 is the first/oldest
    typedef logic [2:0][7:0] t_chars3;

    // Header "%^&" and end marker "@#$"
    localparam t_chars3 HDR_CHARS = {8'h26, 8'h5E, 8'h25};
    localparam t_chars3 TRL_CHARS = {8'h24, 8'h23, 8'h40};

    // Recovered character from the bit unpacker
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_char;

    // Result of one item
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [7:0] data;
        logic       last;
    } t_result;

endpackage

// ----- hdl/lsb_stego_extractor.sv -----
// ============================================================================
// lsb_stego_extractor
// Recovers a keyed text message from the low bits of image channel bytes.
// ============================================================================
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------
//  input    | in  | i_valid / o_ready      | i_channel_byte, i_start_req
//  result   | out | o_valid / i_ready      | o_status, o_payload_char, o_last
//  config   | in  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while results are taken. An accepted item is
//  held in the input register, then the unpack/frame logic runs and loads the
//  result register. A stalled result register holds the input register; input
//  stays ready while the input register is empty or moving on in the same
//  cycle. Reset (synchronous, active low) clears control state and the config
//  registers to width 1, key 0. Config is always ready.
//
module lsb_stego_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input item channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_channel_byte,
    input  logic       i_start_req,
    // result item channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_payload_char,
    output logic       o_last,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import lse_pkg::*;

    // config registers
    logic [2:0] r_bits_per_channel;
    logic [7:0] r_key_byte;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_start;

    // result register
    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic    out_free;
    logic    s1_fire;
    logic    frame_active;
    logic    frame_finished;
    t_char   ch;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_per_channel <= 3'd1;
            r_key_byte         <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BITS_PER_CHANNEL: r_bits_per_channel <= i_cfg_data[2:0];
                CFG_KEY_BYTE:         r_key_byte         <= i_cfg_data;
                default:              ;
            endcase
        end
    end

    // the result register frees when empty or taken this cycle
    assign out_free = !r_out_valid || i_ready;
    assign s1_fire  = r_s1_valid && out_free;
    assign o_ready  = !r_s1_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_byte  <= i_channel_byte;
            r_s1_start <= i_start_req;
        end
    end

    // start_req clears all stream state before its byte is used
    lse_unpack u_unpack (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (s1_fire),
        .i_clear            (r_s1_start),
        .i_step             (s1_fire && frame_active),
        .i_byte             (r_s1_byte),
        .i_bits_per_channel (r_bits_per_channel),
        .i_key_byte         (r_key_byte),
        .o_char             (ch)
    );

    lse_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s1_fire),
        .i_clear    (r_s1_start),
        .i_char     (ch),
        .o_active   (frame_active),
        .o_finished (frame_finished),
        .o_result   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_fire && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && res.valid) begin
            r_out_status <= res.status;
            r_out_char   <= res.data;
            r_out_last   <= res.last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_payload_char = r_out_char;
    assign o_last         = r_out_last;

    // last goes with end or mismatch only, never with a payload character
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_status != ST_PAYLOAD))
                    && (o_status == ST_PAYLOAD || o_status == ST_END
                        || o_status == ST_MISMATCH))
        else $error("status and last disagree");

    // a pending final result means the stream is stopped
    a_last_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> frame_finished)
        else $error("final result without finished state");

    // non-payload results carry a zero character
    a_zero_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_PAYLOAD |-> o_payload_char == 8'd0)
        else $error("character on end or mismatch result");

    // a blocked input register keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid && $stable(r_s1_byte)
                                    && $stable(r_s1_start))
        else $error("input register lost a stalled item");

endmodule

// ----- hdl/lse_unpack.sv -----
// ============================================================================
// lse_unpack
// Bit accumulator: appends the low N bits of each byte, pulls out whole
// characters MSB first and applies the key byte.
// ============================================================================
module lse_unpack (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic          i_clear,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    input  logic [2:0]    i_bits_per_channel,
    input  logic [7:0]    i_key_byte,
    output lse_pkg::t_char o_char
);
    import lse_pkg::*;

    logic [11:0] r_acc;
    logic [2:0]  r_held;
    logic [11:0] n_acc;
    logic [2:0]  n_held;

    logic [2:0]  nb;
    logic [11:0] acc_b;
    logic [2:0]  held_b;
    logic [3:0]  low_bits;
    logic [11:0] shifted;
    logic [3:0]  sum;
    logic [3:0]  rem;

    // clamp width to 1..4
    always_comb begin
        case (i_bits_per_channel)
            3'd0:    nb = 3'd1;
            3'd1:    nb = 3'd1;
            3'd2:    nb = 3'd2;
            3'd3:    nb = 3'd3;
            3'd4:    nb = 3'd4;
            default: nb = 3'd4;
        endcase
    end

    always_comb begin
        acc_b    = i_clear ? 12'd0 : r_acc;
        held_b   = i_clear ? 3'd0 : r_held;
        low_bits = i_byte[3:0] & 4'((5'd1 << nb) - 5'd1);
        shifted  = 12'(acc_b << nb) | {8'd0, low_bits};
        sum      = {1'b0, held_b} + {1'b0, nb};
        rem      = sum - 4'd8;
        n_acc    = acc_b;
        n_held   = held_b;
        o_char   = '0;
        if (i_step) begin
            if (sum >= 4'd8) begin
                o_char.valid = 1'b1;
                o_char.data  = 8'(shifted >> rem) ^ i_key_byte;
                n_held       = rem[2:0];
                n_acc        = shifted & ((12'd1 << rem) - 12'd1);
            end else begin
                n_held = sum[2:0];
                n_acc  = shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
        end else if (i_fire) begin
            r_acc  <= n_acc;
            r_held <= n_held;
        end
    end

    // held bits never reach a whole character between items
    a_held_lt8: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= 3'd7 && (r_acc >> r_held) == 12'd0)
        else $error("accumulator holds bits beyond count");

endmodule

// ----- hdl/lse_frame.sv -----
// ============================================================================
// lse_frame
// Header check, three-deep character window and end-marker detection.
// ============================================================================
module lse_frame (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_clear,
    input  lse_pkg::t_char   i_char,
    output logic             o_active,
    output logic             o_finished,
    output lse_pkg::t_result o_result
);
    import lse_pkg::*;

    logic [2:0] r_seen;
    t_chars3    r_win;
    logic       r_fin;
    logic [2:0] n_seen;
    t_chars3    n_win;
    logic       n_fin;

    logic [2:0] seen_b;
    t_chars3    win_b;
    logic       fin_b;
    logic [1:0] cnt;

    assign o_active   = !fin_b;
    assign o_finished = r_fin;

    always_comb begin
        seen_b   = i_clear ? 3'd0 : r_seen;
        win_b    = i_clear ? '0 : r_win;
        fin_b    = i_clear ? 1'b0 : r_fin;
        n_seen   = seen_b;
        n_win    = win_b;
        n_fin    = fin_b;
        cnt      = 2'd0;
        o_result = '0;
        if (i_char.valid) begin
            if (seen_b < 3'd3) begin
                if (i_char.data != HDR_CHARS[seen_b[1:0]]) begin
                    n_fin           = 1'b1;
                    o_result.valid  = 1'b1;
                    o_result.status = ST_MISMATCH;
                    o_result.last   = 1'b1;
                end else begin
                    n_seen = seen_b + 3'd1;
                end
            end else begin
                cnt        = (seen_b >= 3'd5) ? 2'd2 : 2'(seen_b - 3'd3);
                n_win[cnt] = i_char.data;
                if (cnt != 2'd2) begin
                    n_seen = seen_b + 3'd1;
                end else if (n_win == TRL_CHARS) begin
                    n_fin           = 1'b1;
                    n_seen          = 3'd6;
                    o_result.valid  = 1'b1;
                    o_result.status = ST_END;
                    o_result.last   = 1'b1;
                end else begin
                    o_result.valid  = 1'b1;
                    o_result.status = ST_PAYLOAD;
                    o_result.data   = n_win[0];
                    n_win           = {8'd0, n_win[2], n_win[1]};
                    n_seen          = 3'd5;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_win  <= '0;
            r_fin  <= 1'b0;
        end else if (i_fire) begin
            r_seen <= n_seen;
            r_win  <= n_win;
            r_fin  <= n_fin;
        end
    end

    // count stays in range and reaches six only once the end is found
    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= 3'd6 && (r_seen != 3'd6 || r_fin))
        else $error("character count out of range");

endmodule
